>>> hw/rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition must never be seen outside reset.
`define ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> hw/rtl/lutf8_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lutf8_pkg
// Types, constants and helper functions of the lenient UTF-8 stream decoder.
// ---------------------------------------------------------------------------
package lutf8_pkg;

   localparam int unsigned QDepth = 8;
   localparam int unsigned QPtrW  = 3;
   localparam int unsigned QCntW  = 4;
   localparam int unsigned MaxOut = 4;

   // Lead byte classes (sequence length, zero when invalid).
   localparam logic [2:0] ClsInvalid = 3'd0;
   localparam logic [2:0] ClsAscii   = 3'd1;
   localparam logic [2:0] ClsTwo     = 3'd2;
   localparam logic [2:0] ClsThree   = 3'd3;
   localparam logic [2:0] ClsFour    = 3'd4;

   localparam logic [7:0] Mask2    = 8'hE0;
   localparam logic [7:0] Lead2    = 8'hC0;
   localparam logic [7:0] Mask3    = 8'hF0;
   localparam logic [7:0] Lead3    = 8'hE0;
   localparam logic [7:0] Mask4    = 8'hF8;
   localparam logic [7:0] Lead4    = 8'hF0;
   localparam logic [7:0] MaskCont = 8'hC0;
   localparam logic [7:0] ContTag  = 8'h80;

   typedef logic [20:0] cp_type;

   typedef struct packed {
      cp_type code_point;
      logic   point_present;
      logic   final_result;
      logic   strictly_valid;
      logic   saw_high_byte;
      logic   saw_preferred_script;
      logic   prefer_utf8;
   } result_type;

   function automatic logic [2:0] lead_class(input logic [7:0] c);
      logic [2:0] cls;
      if (!c[7])                       cls = ClsAscii;
      else if ((c & Mask2) == Lead2)   cls = ClsTwo;
      else if ((c & Mask3) == Lead3)   cls = ClsThree;
      else if ((c & Mask4) == Lead4)   cls = ClsFour;
      else                             cls = ClsInvalid;
      return cls;
   endfunction

   function automatic logic in_preferred(input cp_type cp);
      return (cp >= 21'h0000C0 && cp <= 21'h00024F) ||
             (cp >= 21'h001E00 && cp <= 21'h001EFF) ||
             (cp >= 21'h00AC00 && cp <= 21'h00D7AF) ||
             (cp >= 21'h003040 && cp <= 21'h0030FF);
   endfunction

   function automatic cp_type seq_cp(input logic [2:0] len, input logic [7:0] r0,
                                     input logic [7:0] r1, input logic [7:0] r2,
                                     input logic [7:0] r3);
      cp_type cp;
      case (len)
         ClsTwo:   cp = {10'd0, r0[4:0], r1[5:0]};
         ClsThree: cp = {5'd0, r0[3:0], r1[5:0], r2[5:0]};
         ClsFour:  cp = {r0[2:0], r1[5:0], r2[5:0], r3[5:0]};
         default:  cp = {13'd0, r0};
      endcase
      return cp;
   endfunction

endpackage

>>> hw/rtl/lenient_utf8_stream_decoder_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lenient_utf8_stream_decoder_top
// Lenient UTF-8 decoder: bytes in, code points and an end-of-string status out.
// ---------------------------------------------------------------------------
// Usage:
//   req_*  : one string byte per request, req_tlast on the final byte.
//   rsp_*  : one code point per request (rsp_tuser = 1), or a status request
//            (rsp_tlast = 1, rsp_tuser = 0) after the final byte's points.
//   Sequences that are cut off by the end of the string emit their lead
//   byte raw and the rest is scanned again; zero code points are dropped.
// Path: a byte is held in the input register, decoded, and its results are
//   written into the result queue, which drives rsp.
// Throughput: one byte per cycle unless stalled. A byte gives zero or one
//   result; the final byte gives up to four. The decode stage moves items
//   into the 8-entry result queue only while at most four entries are used.
// Reset: synchronous; clears the input valid flag, the result queue
//   pointers and count, and decoder state (pending count, validity, script flags).
// Stall: while rsp_tready is low the queue fills; once more than four
//   results wait, the decode stage holds and req_tready drops.
// ---------------------------------------------------------------------------
module lenient_utf8_stream_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // end_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [20:0] code_point, [21] strictly_valid, [22] saw_high_byte,
   // [23] saw_preferred_script, [24] prefer_utf8, [31:25] zero
   output logic [31:0] rsp_tdata,
   output logic        rsp_tuser,   // point_present
   output logic        rsp_tlast    // final_result
);
   import lutf8_pkg::*;

   logic             in_valid_ff, in_valid_in;
   logic [7:0]       in_byte_ff;
   logic             in_last_ff;

   logic [7:0]       pend_ff [3];
   logic [7:0]       pend_in [3];
   logic [1:0]       pend_cnt_ff, pend_cnt_in;
   logic [2:0]       seq_len_ff, seq_len_in;
   logic [1:0]       strict_rem_ff, strict_rem_in;
   logic             strict_ok_ff, strict_ok_in;
   logic             high_ff, high_in;
   logic             script_ff, script_in;

   result_type       q_ff [QDepth];
   logic [QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0] q_cnt_ff, q_cnt_in;

   logic             proc;
   logic             pop;
   logic [2:0]       cls;
   logic             complete;
   logic [7:0]       run1, run2;
   cp_type           cand [3];
   logic [2:0]       cand_v;
   logic [3:0]       keep;
   logic             script_hit;
   logic             valid_now;
   result_type       item [4];
   result_type       slot [4];
   logic [2:0]       push_n;
   result_type       head;

   assign proc       = in_valid_ff && (q_cnt_ff <= QCntW'(QDepth - MaxOut));
   assign req_tready = !in_valid_ff || proc;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;

   always_comb begin
      cls      = lead_class(in_byte_ff);
      complete = (pend_cnt_ff != 2'd0) && (({1'b0, pend_cnt_ff} + 3'd1) >= seq_len_ff);
      run1     = (pend_cnt_ff >= 2'd2) ? pend_ff[1] : in_byte_ff;
      run2     = (pend_cnt_ff == 2'd3) ? pend_ff[2] : in_byte_ff;
      cand[0]  = '0;
      cand[1]  = '0;
      cand[2]  = '0;
      cand_v   = '0;
      pend_in     = pend_ff;
      pend_cnt_in = pend_cnt_ff;
      seq_len_in  = seq_len_ff;

      if (pend_cnt_ff == 2'd0) begin
         if (!in_last_ff && cls >= ClsTwo) begin
            pend_in[0]  = in_byte_ff;
            pend_cnt_in = 2'd1;
            seq_len_in  = cls;
         end else begin
            cand[0]   = {13'd0, in_byte_ff};
            cand_v[0] = 1'b1;
         end
      end else if (complete) begin
         cand[0]     = seq_cp(seq_len_ff, pend_ff[0], run1, run2, in_byte_ff);
         cand_v[0]   = 1'b1;
         pend_cnt_in = 2'd0;
         seq_len_in  = ClsInvalid;
      end else if (!in_last_ff) begin
         pend_in[pend_cnt_ff] = in_byte_ff;
         pend_cnt_in          = pend_cnt_ff + 2'd1;
      end else begin
         // cut-off lead goes out raw, the rest is scanned again
         cand[0]   = {13'd0, pend_ff[0]};
         cand_v[0] = 1'b1;
         if (pend_cnt_ff == 2'd1) begin
            cand[1]   = {13'd0, in_byte_ff};
            cand_v[1] = 1'b1;
         end else if (lead_class(pend_ff[1]) == ClsTwo) begin
            cand[1]   = seq_cp(ClsTwo, pend_ff[1], in_byte_ff, in_byte_ff, in_byte_ff);
            cand_v[1] = 1'b1;
         end else begin
            cand[1]   = {13'd0, pend_ff[1]};
            cand[2]   = {13'd0, in_byte_ff};
            cand_v[1] = 1'b1;
            cand_v[2] = 1'b1;
         end
      end

      keep[0] = cand_v[0] && (cand[0] != '0);
      keep[1] = cand_v[1] && (cand[1] != '0);
      keep[2] = cand_v[2] && (cand[2] != '0);
      keep[3] = in_last_ff;
      script_hit = (keep[0] && in_preferred(cand[0])) ||
                   (keep[1] && in_preferred(cand[1])) ||
                   (keep[2] && in_preferred(cand[2]));

      strict_rem_in = strict_rem_ff;
      strict_ok_in  = strict_ok_ff;
      if (strict_rem_ff != 2'd0) begin
         if ((in_byte_ff & MaskCont) != ContTag) strict_ok_in = 1'b0;
         strict_rem_in = strict_rem_ff - 2'd1;
      end else if (cls == ClsInvalid) begin
         strict_ok_in = 1'b0;
      end else begin
         strict_rem_in = 2'(cls - 3'd1);
      end
      high_in   = high_ff || in_byte_ff[7];
      script_in = script_ff || script_hit;
      valid_now = strict_ok_in && (strict_rem_in == 2'd0);

      for (int i = 0; i < 3; i++) begin
         item[i] = '{code_point: cand[i], point_present: 1'b1, default: 1'b0};
      end
      item[3] = '{code_point: '0, point_present: 1'b0, final_result: 1'b1,
                  strictly_valid: valid_now, saw_high_byte: high_in,
                  saw_preferred_script: script_in,
                  prefer_utf8: valid_now && high_in && script_in};

      if (in_last_ff) begin
         pend_cnt_in   = 2'd0;
         seq_len_in    = ClsInvalid;
         strict_rem_in = 2'd0;
         strict_ok_in  = 1'b1;
         high_in       = 1'b0;
         script_in     = 1'b0;
      end

      push_n = 3'd0;
      for (int i = 0; i < 4; i++) begin
         slot[i] = item[3];
      end
      for (int i = 0; i < 4; i++) begin
         if (keep[i]) begin
            slot[push_n[1:0]] = item[i];
            push_n            = push_n + 3'd1;
         end
      end
      if (!proc) push_n = 3'd0;
   end

   assign head       = q_ff[rd_ptr_ff];
   assign rsp_tvalid = q_cnt_ff != '0;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {7'd0, head.prefer_utf8, head.saw_preferred_script,
                        head.saw_high_byte, head.strictly_valid, head.code_point};
   assign rsp_tuser  = head.point_present;
   assign rsp_tlast  = head.final_result;

   assign wr_ptr_in = wr_ptr_ff + QPtrW'(push_n);
   assign rd_ptr_in = rd_ptr_ff + QPtrW'(pop);
   assign q_cnt_in  = q_cnt_ff + QCntW'(push_n) - QCntW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         pend_cnt_ff   <= 2'd0;
         seq_len_ff    <= ClsInvalid;
         strict_rem_ff <= 2'd0;
         strict_ok_ff  <= 1'b1;
         high_ff       <= 1'b0;
         script_ff     <= 1'b0;
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         q_cnt_ff      <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (proc) begin
            pend_cnt_ff   <= pend_cnt_in;
            seq_len_ff    <= seq_len_in;
            strict_rem_ff <= strict_rem_in;
            strict_ok_ff  <= strict_ok_in;
            high_ff       <= high_in;
            script_ff     <= script_in;
         end
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         q_cnt_ff  <= q_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
      if (proc) pend_ff <= pend_in;
      for (int i = 0; i < 4; i++) begin
         if (3'(i) < push_n) q_ff[wr_ptr_ff + QPtrW'(i)] <= slot[i];
      end
   end

endmodule

>>> hw/rtl/lutf8_checker.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lutf8_checker
// Port-level checks on the result stream of the lenient UTF-8 decoder.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module lutf8_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser,
   input logic        rsp_tlast
);

   `ASSERT_ALWAYS(a_status_no_point, clock, reset, rsp_tvalid && rsp_tlast |-> !rsp_tuser && rsp_tdata[20:0] == 21'd0, "status request carries a code point")

   `ASSERT_ALWAYS(a_point_no_status, clock, reset, rsp_tvalid && !rsp_tlast |-> rsp_tuser && rsp_tdata[20:0] != 21'd0 && rsp_tdata[31:21] == 11'd0, "code point request malformed")

   `ASSERT_NEVER(a_prefer_flags, clock, reset, rsp_tvalid && rsp_tdata[24] && !(rsp_tdata[21] && rsp_tdata[22] && rsp_tdata[23]), "prefer_utf8 without all three flags")

   `ASSERT_ALWAYS(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast), "stalled request changed")

endmodule

bind lenient_utf8_stream_decoder_top lutf8_checker u_lutf8_checker (.*);
